[hdl/pcm_linear_tail_fade_macros.svh]
// assertion macros used by the checker file
`ifndef PCM_LINEAR_TAIL_FADE_MACROS_SVH
`define PCM_LINEAR_TAIL_FADE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PLTF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcm_linear_tail_fade check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PLTF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcm_linear_tail_fade check failed");

`endif

[hdl/pltf_pkg.sv]
// types and constants of the pcm linear tail fade block
`default_nettype none

package pltf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CLIP_W      = 24;
    localparam int FADE_W      = 10;
    localparam int CFG_INDEX_W = 4;

    localparam logic [FADE_W-1:0] FADE_LIMIT_RESET = 10'd320;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_SAMPLES = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_LIMIT   = 4'd1;

    // one classified sample handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [FADE_W-1:0]          gain;
        logic [FADE_W-1:0]          fade_len;
        logic                       fade;
        logic                       clip_end;
    } pltf_item_t;

endpackage

`default_nettype wire

[hdl/pcm_linear_tail_fade.sv]
// top level of the pcm linear tail fade block
//
// Usage: signed 16-bit PCM samples enter on the s_axis channel and leave on
// m_axis, one result per sample, in order. m_axis_tlast marks the last sample
// of each clip. Samples pass unchanged, except the last F of each clip, F being
// the smaller of clip_samples and fade_limit, which follow a linear ramp down
// to zero. Registers are written on the cfg channel (index 0 clip_samples,
// index 1 fade_limit) while no sample is in flight; cfg_ready is always high.
// A faded sample passes the queue and the back end states IDLE, MUL, ABS, DIV
// and DONE into the output register; a passed sample skips ABS and DIV. The
// back end takes a new sample only once the last is in the output register.
// Its bit-serial divider gives one quotient bit per cycle, 25 bits.
// The front end classifies samples in the cycle they arrive and places them
// in a short queue, so it keeps accepting while the back end divides, as long
// as the queue has room. Reset clears the clip position, sets clip_samples to
// 0 and fade_limit to 320, and empties the queue and output register.
// When the receiver stalls, the result holds in the output register, the
// back end and then the queue fill, and s_axis_tready drops.
`default_nettype none

module pcm_linear_tail_fade
    import pltf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CLIP_W-1:0]      cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [15:0]            s_axis_tdata,   // [15:0] sample_in
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [15:0]                 m_axis_tdata,   // [15:0] sample_out
    output logic                        m_axis_tlast    // clip_end
);

    logic       fq_valid;
    logic       fq_ready;
    pltf_item_t fq_item;
    logic       qb_valid;
    logic       qb_ready;
    pltf_item_t qb_item;

    // classification and position tracking
    pltf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_item    (fq_item)
    );

    // decoupling queue
    pltf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // ramp arithmetic and output register
    pltf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_item     (qb_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (m_axis_tdata),
        .out_end    (m_axis_tlast)
    );

endmodule

`default_nettype wire

[hdl/pltf_front.sv]
// front end: configuration registers, clip position and sample classification
`default_nettype none

module pltf_front
    import pltf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CLIP_W-1:0]      cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_W-1:0]    in_sample,
    output logic                        q_valid,
    input  wire logic                   q_ready,
    output pltf_item_t                  q_item
);

    logic [CLIP_W-1:0] clip_samples_reg, clip_samples_next;
    logic [FADE_W-1:0] fade_limit_reg, fade_limit_next;
    logic [CLIP_W-1:0] clip_position_reg, clip_position_next;

    logic              accept;
    logic              clip_on;
    logic [FADE_W-1:0] fade_len;
    logic              is_end;
    logic [CLIP_W-1:0] pos_eff;
    logic [CLIP_W-1:0] gain_wide;
    logic [CLIP_W:0]   pos_plus_fade;
    logic              in_fade;

    assign cfg_ready = 1'b1;
    assign in_ready  = q_ready;
    assign q_valid   = in_valid;
    assign accept    = in_valid && q_ready;

    // register writes
    always_comb
    begin
        clip_samples_next = clip_samples_reg;
        fade_limit_next   = fade_limit_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CLIP_SAMPLES: clip_samples_next = cfg_data;
                CFG_FADE_LIMIT:   fade_limit_next   = cfg_data[FADE_W-1:0];
                default:          ;
            endcase
        end
    end

    // ramp length is the smaller of clip length and fade limit
    assign clip_on  = (clip_samples_reg != '0);
    assign fade_len = (clip_samples_reg < {{(CLIP_W-FADE_W){1'b0}}, fade_limit_reg})
                      ? clip_samples_reg[FADE_W-1:0] : fade_limit_reg;

    // last sample of the clip, also when the position ran past the end
    assign is_end  = ({1'b0, clip_position_reg} + 1'b1) >= {1'b0, clip_samples_reg};
    assign pos_eff = is_end ? (clip_samples_reg - 1'b1) : clip_position_reg;

    // inside the tail when position + F reaches the clip length
    assign pos_plus_fade = {1'b0, pos_eff} + {{(CLIP_W+1-FADE_W){1'b0}}, fade_len};
    assign in_fade       = clip_on && (fade_len != '0) && (pos_plus_fade >= {1'b0, clip_samples_reg});

    // gain F-k-1 equals samples left after this one
    assign gain_wide = clip_samples_reg - 1'b1 - pos_eff;

    always_comb
    begin
        q_item.sample   = in_sample;
        q_item.gain     = gain_wide[FADE_W-1:0];
        q_item.fade_len = fade_len;
        q_item.fade     = in_fade;
        q_item.clip_end = clip_on && is_end;
    end

    // position advance per accepted sample
    always_comb
    begin
        clip_position_next = clip_position_reg;
        if (accept)
        begin
            if (!clip_on || is_end)
                clip_position_next = '0;
            else
                clip_position_next = clip_position_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_samples_reg  <= '0;
            fade_limit_reg    <= FADE_LIMIT_RESET;
            clip_position_reg <= '0;
        end
        else
        begin
            clip_samples_reg  <= clip_samples_next;
            fade_limit_reg    <= fade_limit_next;
            clip_position_reg <= clip_position_next;
        end
    end

endmodule

`default_nettype wire

[hdl/pltf_queue.sv]
// short queue of classified samples between front and back
`default_nettype none

module pltf_queue
    import pltf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  pltf_item_t in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output pltf_item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pltf_item_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_item;
    end

endmodule

`default_nettype wire

[hdl/pltf_back.sv]
// back end: ramp multiply, bit-serial divide and output register
`default_nettype none

module pltf_back
    import pltf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  pltf_item_t                q_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [SAMPLE_W-1:0]       out_sample,
    output logic                      out_end
);

    localparam int PROD_W = SAMPLE_W + FADE_W + 1;
    localparam int MAG_W  = PROD_W - 2;
    localparam int CNT_W  = $clog2(MAG_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    pltf_item_t                 item_reg, item_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       neg_reg, neg_next;
    logic [MAG_W-1:0]           dvd_reg, dvd_next;
    logic [FADE_W-1:0]          rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]        out_sample_reg, out_sample_next;
    logic                       out_end_reg, out_end_next;

    logic [PROD_W-1:0]          prod_abs;
    logic [FADE_W:0]            trial;
    logic                       trial_ge;
    logic [SAMPLE_W-1:0]        quo;
    logic [SAMPLE_W-1:0]        result;

    assign q_ready    = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_end    = out_end_reg;

    // magnitude of the product, fits MAG_W bits
    assign prod_abs = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    // one restoring divide step
    assign trial    = {rem_reg, dvd_reg[MAG_W-1]};
    assign trial_ge = (trial >= {1'b0, item_reg.fade_len});

    // quotient stays below full scale, so the sign is applied on 16 bits
    assign quo    = dvd_reg[SAMPLE_W-1:0];
    assign result = !item_reg.fade ? item_reg.sample
                  : (neg_reg ? SAMPLE_W'(-quo) : quo);

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_end_next    = out_end_reg;

        // output register empties on a transfer
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    item_next  = q_item;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(item_reg.sample)
                           * PROD_W'($signed({1'b0, item_reg.gain}));
                state_next = item_reg.fade ? ST_ABS : ST_DONE;
            end
            ST_ABS:
            begin
                neg_next   = prod_reg[PROD_W-1];
                dvd_next   = prod_abs[MAG_W-1:0];
                rem_next   = '0;
                cnt_next   = CNT_W'(MAG_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? FADE_W'(trial - {1'b0, item_reg.fade_len})
                                    : trial[FADE_W-1:0];
                dvd_next = {dvd_reg[MAG_W-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = result;
                    out_end_next    = item_reg.clip_end;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output valid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        out_sample_reg <= out_sample_next;
        out_end_reg    <= out_end_next;
    end

endmodule

`default_nettype wire

[hdl/pltf_checker.sv]
// port-level checker for the pcm linear tail fade block, with its bind
`default_nettype none

`include "pcm_linear_tail_fade_macros.svh"

module pltf_checker
    import pltf_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready,
    input wire logic [CFG_INDEX_W-1:0] cfg_index,
    input wire logic [CLIP_W-1:0]      cfg_data,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [15:0]            m_axis_tdata,
    input wire logic                   m_axis_tlast
);

    logic [7:0] pending_reg;
    logic       clip_zero_reg;
    logic       fade_zero_reg;
    logic       in_xfer;
    logic       out_xfer;
    logic       cfg_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign cfg_xfer = cfg_valid && cfg_ready;

    // samples accepted but not yet delivered, and mirrored register state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            clip_zero_reg <= 1'b1;
            fade_zero_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer && !out_xfer)
                pending_reg <= pending_reg + 1'b1;
            else if (out_xfer && !in_xfer)
                pending_reg <= pending_reg - 1'b1;
            if (cfg_xfer && (cfg_index == CFG_CLIP_SAMPLES))
                clip_zero_reg <= (cfg_data == '0);
            if (cfg_xfer && (cfg_index == CFG_FADE_LIMIT))
                fade_zero_reg <= (cfg_data[FADE_W-1:0] == '0);
        end
    end

    // stalled result stays offered and unchanged
    `PLTF_ASSERT_NEXT(a_out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `PLTF_ASSERT_NEXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // no result without an accepted sample behind it
    `PLTF_ASSERT_NOW(a_no_spurious_out, m_axis_tvalid, pending_reg != 8'd0)

    // last sample of a clip ends the ramp at silence
    `PLTF_ASSERT_NOW(a_last_is_silent, m_axis_tvalid && m_axis_tlast && !fade_zero_reg, m_axis_tdata == 16'd0)

    // no clip end marks while clips are switched off
    `PLTF_ASSERT_NOW(a_no_end_when_off, m_axis_tvalid && clip_zero_reg, !m_axis_tlast)

endmodule

bind pcm_linear_tail_fade pltf_checker u_pltf_checker (.*);

`default_nettype wire
